### src/dms_pkg.sv
`timescale 1ns / 1ps

package dms_pkg;

    // fixed field widths
    localparam int LIGHT_W            = 10;
    localparam int THR_W              = 16;
    localparam int TICK_W             = 8;
    localparam int HYST_W             = 10;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 16;
    localparam int SAMPLE_BITS_DEFAULT = 10;

    // reset and default values
    localparam logic [THR_W-1:0]  DEFAULT_THRESHOLD     = 16'd500;
    localparam logic [THR_W-1:0]  THR_BLANK             = 16'hFFFF;
    localparam logic [TICK_W-1:0] DEFAULT_MOVE_LIMIT    = 8'd60;
    localparam logic [TICK_W-1:0] DEFAULT_RELEASE_LIMIT = 8'd20;
    localparam logic [TICK_W-1:0] DEFAULT_CONFIRM_COUNT = 8'd20;
    localparam logic [HYST_W-1:0] DEFAULT_HYSTERESIS    = 10'd15;
    localparam logic [TICK_W-1:0] TICK_MAX              = 8'hFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS      = 3'd4;

    typedef enum logic [2:0] {
        ST_ERROR     = 3'd0,
        ST_MOVE_UP   = 3'd1,
        ST_REL_UP    = 3'd2,
        ST_IDLE_UP   = 3'd3,
        ST_MOVE_DOWN = 3'd4,
        ST_REL_DOWN  = 3'd5,
        ST_IDLE_DOWN = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_UP   = 2'd1,
        DRV_DOWN = 2'd2
    } drive_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_UPPER  = 2'd1,
        OP_LOWER  = 2'd2,
        OP_BUTTON = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t              opcode;
        logic                 upper_switch;
        logic                 lower_switch;
        logic                 set_pressed;
        logic                 close_pressed;
        logic                 open_pressed;
        logic [LIGHT_W-1:0]   light_sample;
    } item_t;

    typedef struct packed {
        logic [TICK_W-1:0] move_limit;
        logic [TICK_W-1:0] release_limit;
        logic [TICK_W-1:0] confirm_count;
        logic [HYST_W-1:0] hysteresis;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [THR_W-1:0] value;
    } thr_load_t;

    typedef struct packed {
        mode_t             mode;
        drive_t            motor;
        logic [THR_W-1:0]  threshold;
        logic              capture;
        logic [TICK_W-1:0] confirm;
    } result_t;

endpackage

### src/dms_if.sv
`timescale 1ns / 1ps

interface door_in_if #(parameter int SAMPLE_BITS = 10);
    logic                   valid;
    logic                   ready;
    logic [1:0]             opcode;
    logic                   upper_switch;
    logic                   lower_switch;
    logic                   set_pressed;
    logic                   close_pressed;
    logic                   open_pressed;
    logic [SAMPLE_BITS-1:0] light_sample;

    modport source (
        output valid, opcode, upper_switch, lower_switch,
               set_pressed, close_pressed, open_pressed, light_sample,
        input  ready
    );

    modport sink (
        input  valid, opcode, upper_switch, lower_switch,
               set_pressed, close_pressed, open_pressed, light_sample,
        output ready
    );
endinterface

interface door_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  door_state;
    logic [1:0]  motor_drive;
    logic [15:0] threshold_now;
    logic        capture_armed;
    logic [7:0]  confirm_ticks;

    modport source (
        output valid, door_state, motor_drive, threshold_now,
               capture_armed, confirm_ticks,
        input  ready
    );

    modport sink (
        input  valid, door_state, motor_drive, threshold_now,
               capture_armed, confirm_ticks,
        output ready
    );
endinterface

### src/dms_cfg_regs.sv
`timescale 1ns / 1ps

module dms_cfg_regs
    import dms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output thr_load_t             thr_load
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOVE_LIMIT:    cfg_next.move_limit    = cfg_data[TICK_W-1:0];
                CFG_RELEASE_LIMIT: cfg_next.release_limit = cfg_data[TICK_W-1:0];
                CFG_CONFIRM_COUNT: cfg_next.confirm_count = cfg_data[TICK_W-1:0];
                CFG_HYSTERESIS:    cfg_next.hysteresis    = cfg_data[HYST_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_limit    <= DEFAULT_MOVE_LIMIT;
            cfg_reg.release_limit <= DEFAULT_RELEASE_LIMIT;
            cfg_reg.confirm_count <= DEFAULT_CONFIRM_COUNT;
            cfg_reg.hysteresis    <= DEFAULT_HYSTERESIS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // threshold write goes straight into the working threshold
    always_comb
    begin
        thr_load.valid = cfg_we && (cfg_index == CFG_START_THRESHOLD);
        if (cfg_data[THR_W-1:0] == '0 || cfg_data[THR_W-1:0] == THR_BLANK)
            thr_load.value = DEFAULT_THRESHOLD;
        else
            thr_load.value = cfg_data[THR_W-1:0];
    end

    assign cfg = cfg_reg;

endmodule

### src/dms_seq.sv
`timescale 1ns / 1ps

module dms_seq
    import dms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  item_t     item,
    input  cfg_t      cfg,
    input  thr_load_t thr_load,
    output result_t   result,
    output mode_t     mode_now
);

    typedef struct packed {
        mode_t             mode;
        logic              entry_pending;
        drive_t            motor;
        logic [TICK_W-1:0] travel;
        logic [TICK_W-1:0] release_cnt;
        logic [TICK_W-1:0] light;
    } run_t;

    run_t             run_reg;
    run_t             run_next;
    logic             first_reg;
    logic             first_next;
    logic [THR_W-1:0] thr_reg;
    logic [THR_W-1:0] thr_next;
    logic             cap_reg;
    logic             cap_next;
    logic             light_cond;
    logic [THR_W-1:0] sample_ext;

    function automatic logic [TICK_W-1:0] sat_inc(logic [TICK_W-1:0] v);
        return (v == TICK_MAX) ? v : v + TICK_W'(1);
    endfunction

    function automatic run_t do_entry(run_t s, logic up_sw, logic low_sw);
        run_t r;
        r = s;
        if (s.entry_pending)
        begin
            r.entry_pending = 1'b0;
            case (s.mode)
                ST_MOVE_UP, ST_MOVE_DOWN:
                begin
                    if (up_sw || low_sw)
                    begin
                        // end stop still pressed when a move begins
                        r.mode  = ST_ERROR;
                        r.motor = DRV_STOP;
                    end
                    else
                    begin
                        r.motor  = (s.mode == ST_MOVE_UP) ? DRV_UP : DRV_DOWN;
                        r.travel = '0;
                    end
                end
                ST_REL_UP:
                begin
                    r.motor       = DRV_DOWN;
                    r.release_cnt = '0;
                end
                ST_REL_DOWN:
                begin
                    r.motor       = DRV_UP;
                    r.release_cnt = '0;
                end
                ST_IDLE_UP, ST_IDLE_DOWN:
                begin
                    r.motor = DRV_STOP;
                    r.light = '0;
                end
                default:
                begin
                    r.mode  = ST_ERROR;
                    r.motor = DRV_STOP;
                end
            endcase
        end
        return r;
    endfunction

    assign sample_ext = THR_W'(item.light_sample);

    always_comb
    begin
        run_next   = run_reg;
        thr_next   = thr_reg;
        cap_next   = cap_reg;
        first_next = 1'b0;
        light_cond = 1'b0;

        // power-on release
        if (first_reg && item.upper_switch)
        begin
            run_next.mode          = ST_REL_UP;
            run_next.entry_pending = 1'b1;
        end

        case (item.opcode)
            OP_UPPER:
            begin
                if (run_next.mode == ST_MOVE_UP && item.upper_switch)
                begin
                    run_next.mode          = ST_REL_UP;
                    run_next.entry_pending = 1'b1;
                end
                else if (run_next.mode == ST_REL_UP && !item.upper_switch)
                begin
                    run_next.mode          = ST_IDLE_UP;
                    run_next.entry_pending = 1'b1;
                end
            end
            OP_LOWER:
            begin
                if (run_next.mode == ST_MOVE_DOWN && item.lower_switch)
                begin
                    run_next.mode          = ST_REL_DOWN;
                    run_next.entry_pending = 1'b1;
                end
                else if (run_next.mode == ST_REL_DOWN && !item.lower_switch)
                begin
                    run_next.mode          = ST_IDLE_DOWN;
                    run_next.entry_pending = 1'b1;
                end
            end
            OP_BUTTON:
            begin
                // set hides the other buttons even when it does nothing
                if (item.set_pressed)
                begin
                    if (run_next.mode == ST_IDLE_UP || run_next.mode == ST_IDLE_DOWN)
                        cap_next = 1'b1;
                end
                else if (item.close_pressed)
                begin
                    if (run_next.mode == ST_IDLE_UP)
                    begin
                        run_next.mode          = ST_MOVE_DOWN;
                        run_next.entry_pending = 1'b1;
                    end
                end
                else if (item.open_pressed)
                begin
                    if (run_next.mode == ST_IDLE_DOWN)
                    begin
                        run_next.mode          = ST_MOVE_UP;
                        run_next.entry_pending = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        run_next = do_entry(run_next, item.upper_switch, item.lower_switch);

        if (item.opcode == OP_TICK)
        begin
            case (run_next.mode)
                ST_ERROR:
                begin
                end
                ST_MOVE_UP, ST_MOVE_DOWN:
                begin
                    run_next.travel = sat_inc(run_next.travel);
                    if (run_next.travel > cfg.move_limit)
                    begin
                        run_next.mode  = ST_ERROR;
                        run_next.motor = DRV_STOP;
                    end
                end
                ST_REL_UP, ST_REL_DOWN:
                begin
                    run_next.release_cnt = sat_inc(run_next.release_cnt);
                    if (run_next.release_cnt > cfg.release_limit)
                    begin
                        run_next.mode  = ST_ERROR;
                        run_next.motor = DRV_STOP;
                    end
                end
                ST_IDLE_UP, ST_IDLE_DOWN:
                begin
                    if (cap_next)
                    begin
                        thr_next = sample_ext;
                        cap_next = 1'b0;
                    end
                    // closing needs darker than threshold, opening brighter plus hysteresis
                    if (run_next.mode == ST_IDLE_UP)
                        light_cond = sample_ext < thr_next;
                    else
                        light_cond = (THR_W+1)'(sample_ext) >
                                     ((THR_W+1)'(thr_next) + (THR_W+1)'(cfg.hysteresis));
                    run_next.light = light_cond ? sat_inc(run_next.light) : '0;
                    if (run_next.light > cfg.confirm_count)
                    begin
                        run_next.mode = (run_next.mode == ST_IDLE_UP) ? ST_MOVE_DOWN
                                                                      : ST_MOVE_UP;
                        run_next.entry_pending = 1'b1;
                    end
                end
                default:
                begin
                    run_next.mode          = ST_ERROR;
                    run_next.motor         = DRV_STOP;
                    run_next.entry_pending = 1'b0;
                end
            endcase
            run_next = do_entry(run_next, item.upper_switch, item.lower_switch);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg.mode          <= ST_MOVE_UP;
            run_reg.entry_pending <= 1'b1;
            run_reg.motor         <= DRV_STOP;
            run_reg.travel        <= '0;
            run_reg.release_cnt   <= '0;
            run_reg.light         <= '0;
            first_reg             <= 1'b1;
            cap_reg               <= 1'b0;
            thr_reg               <= DEFAULT_THRESHOLD;
        end
        else
        begin
            if (fire)
            begin
                run_reg   <= run_next;
                first_reg <= first_next;
                cap_reg   <= cap_next;
            end
            if (thr_load.valid)
                thr_reg <= thr_load.value;
            else if (fire)
                thr_reg <= thr_next;
        end
    end

    always_comb
    begin
        result.mode      = run_next.mode;
        result.motor     = run_next.motor;
        result.threshold = thr_next;
        result.capture   = cap_next;
        result.confirm   = run_next.light;
    end

    assign mode_now = run_reg.mode;

endmodule

### src/door_motor_sequencer_top.sv
`timescale 1ns / 1ps

// Door motor sequencer: steps the motor through error, moving up, releasing
// up, idle up, moving down, releasing down and idle down, driven by ticks,
// limit-switch changes and button changes, and returns one result item per
// input item (state, motor command, working threshold, capture flag and the
// light confirmation count). It takes one item per clock cycle unless the
// result side stalls; each item is held in the input register and is folded
// into the state in the combinational update that loads the result register,
// from which its result is then offered. The input side keeps
// accepting while a result waits, as long as the result register frees up
// in the same cycle. Configuration writes take effect on the next edge and
// belong to periods when no item is in flight; writing the start threshold
// reloads the working threshold (0 or all ones select 500).
module door_motor_sequencer_top
    import dms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    door_in_if.sink               in_ch,
    door_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // input register
    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    item_t   in_item_next;
    item_t   in_item_bus;

    // light sample at the width the input channel carries
    logic [SAMPLE_BITS-1:0] sample_raw;

    // result register
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_item_reg;
    result_t out_item_next;

    logic      fire;
    cfg_t      cfg;
    thr_load_t thr_load;
    result_t   step_result;
    mode_t     mode_now;

    // state update happens when the held item can move into a free result slot
    assign fire        = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || fire;

    assign sample_raw = in_ch.light_sample;

    // only the low sample bits carry the light reading
    always_comb
    begin
        in_item_bus.opcode        = opcode_t'(in_ch.opcode);
        in_item_bus.upper_switch  = in_ch.upper_switch;
        in_item_bus.lower_switch  = in_ch.lower_switch;
        in_item_bus.set_pressed   = in_ch.set_pressed;
        in_item_bus.close_pressed = in_ch.close_pressed;
        in_item_bus.open_pressed  = in_ch.open_pressed;
        in_item_bus.light_sample  = LIGHT_W'(sample_raw);
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (in_ch.ready)
        begin
            in_valid_next = in_ch.valid;
            in_item_next  = in_item_bus;
        end

        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_item_next  = step_result;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    dms_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg),
        .thr_load (thr_load)
    );

    dms_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .thr_load(thr_load),
        .result  (step_result),
        .mode_now(mode_now)
    );

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.door_state    = out_item_reg.mode;
    assign out_ch.motor_drive   = out_item_reg.motor;
    assign out_ch.threshold_now = out_item_reg.threshold;
    assign out_ch.capture_armed = out_item_reg.capture;
    assign out_ch.confirm_ticks = out_item_reg.confirm;

`ifndef SYNTH
    // error is terminal
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_now == ST_ERROR |=> mode_now == ST_ERROR)
        else $error("left error state");

    // motor stopped in error and idle states
    a_stop_when_parked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.mode == ST_ERROR ||
                          out_item_reg.mode == ST_IDLE_UP ||
                          out_item_reg.mode == ST_IDLE_DOWN)
        |-> out_item_reg.motor == DRV_STOP)
        else $error("motor running while parked");

    // moving states drive in their own direction
    a_move_direction: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.mode == ST_MOVE_UP ||
                          out_item_reg.mode == ST_MOVE_DOWN)
        |-> out_item_reg.motor == ((out_item_reg.mode == ST_MOVE_UP) ? DRV_UP : DRV_DOWN))
        else $error("motor direction does not match move state");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !fire)
        else $error("result register overwritten while stalled");
`endif

endmodule

### tb/tb_door_motor_sequencer_top.sv
`timescale 1ns / 1ps

module tb_door_motor_sequencer_top;
    import dms_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int PHASE_ITEMS     = 205;
    localparam int HOLD_OFF_AT     = 600;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 6;
    localparam int SAMPLE_MAX      = (1 << LIGHT_W) - 1;

    // ways the run is finally driven into the error state
    localparam int END_BY_TRAVEL  = 0;
    localparam int END_BY_RELEASE = 1;
    localparam int END_BY_ENDSTOP = 2;

    // door state predictor plus the queue of results it still owes
    class door_result_board;
        mode_t       mode;
        drive_t      motor;
        bit          entry_pending;
        bit          first_item;
        logic [7:0]  travel_cnt;
        logic [7:0]  release_cnt;
        logic [7:0]  light_cnt;
        logic [15:0] thr;
        bit          capture;
        logic [7:0]  move_lim;
        logic [7:0]  rel_lim;
        logic [7:0]  confirm_lim;
        logic [9:0]  hyst;
        result_t     owed_results[$];
        int          mismatches;
        int          items_seen;
        int          results_seen;
        int          captures_taken;
        int          mode_hits[8];

        function new();
            mode           = ST_MOVE_UP;
            motor          = DRV_STOP;
            entry_pending  = 1'b1;
            first_item     = 1'b1;
            travel_cnt     = '0;
            release_cnt    = '0;
            light_cnt      = '0;
            thr            = DEFAULT_THRESHOLD;
            capture        = 1'b0;
            move_lim       = DEFAULT_MOVE_LIMIT;
            rel_lim        = DEFAULT_RELEASE_LIMIT;
            confirm_lim    = DEFAULT_CONFIRM_COUNT;
            hyst           = DEFAULT_HYSTERESIS;
            mismatches     = 0;
            items_seen     = 0;
            results_seen   = 0;
            captures_taken = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_START_THRESHOLD:
                    thr = (data == '0 || data == THR_BLANK) ? DEFAULT_THRESHOLD : data;
                CFG_MOVE_LIMIT:    move_lim    = data[7:0];
                CFG_RELEASE_LIMIT: rel_lim     = data[7:0];
                CFG_CONFIRM_COUNT: confirm_lim = data[7:0];
                CFG_HYSTERESIS:    hyst        = data[9:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] bump(logic [7:0] v);
            return (v == TICK_MAX) ? v : v + 8'd1;
        endfunction

        function void go_error();
            mode          = ST_ERROR;
            motor         = DRV_STOP;
            entry_pending = 1'b0;
        endfunction

        // forward by one step, idle down wraps to moving up, or straight to error
        function void request(mode_t target);
            if (target == mode)
                return;
            if (target == ST_ERROR)
            begin
                go_error();
                return;
            end
            if (target != ST_MOVE_UP)
            begin
                if (int'(target) == int'(mode) + 1)
                begin
                    mode          = target;
                    entry_pending = 1'b1;
                end
            end
            else if (mode == ST_IDLE_DOWN)
            begin
                mode          = target;
                entry_pending = 1'b1;
            end
        endfunction

        function void run_entry(logic up_sw, logic low_sw);
            if (!entry_pending)
                return;
            entry_pending = 1'b0;
            case (mode)
                ST_MOVE_UP, ST_MOVE_DOWN:
                begin
                    if (up_sw || low_sw)
                        go_error();
                    else
                    begin
                        if (mode == ST_MOVE_UP)
                            motor = DRV_UP;
                        else
                            motor = DRV_DOWN;
                        travel_cnt = '0;
                    end
                end
                ST_REL_UP:
                begin
                    motor       = DRV_DOWN;
                    release_cnt = '0;
                end
                ST_REL_DOWN:
                begin
                    motor       = DRV_UP;
                    release_cnt = '0;
                end
                ST_IDLE_UP, ST_IDLE_DOWN:
                begin
                    motor     = DRV_STOP;
                    light_cnt = '0;
                end
                default: go_error();
            endcase
        endfunction

        function void idle_tick(logic [LIGHT_W-1:0] sample);
            logic [16:0] bright_level;
            bit          cond;
            if (capture)
            begin
                thr     = 16'(sample);
                capture = 1'b0;
                captures_taken++;
            end
            if (mode == ST_IDLE_UP)
                cond = 16'(sample) < thr;
            else
            begin
                bright_level = 17'(thr) + 17'(hyst);
                cond         = 17'(sample) > bright_level;
            end
            light_cnt = cond ? bump(light_cnt) : 8'd0;
            if (light_cnt > confirm_lim)
            begin
                if (mode == ST_IDLE_UP)
                    request(ST_MOVE_DOWN);
                else
                    request(ST_MOVE_UP);
            end
        endfunction

        function void tick(logic [LIGHT_W-1:0] sample);
            case (mode)
                ST_ERROR: ;
                ST_MOVE_UP, ST_MOVE_DOWN:
                begin
                    travel_cnt = bump(travel_cnt);
                    if (travel_cnt > move_lim)
                        request(ST_ERROR);
                end
                ST_REL_UP, ST_REL_DOWN:
                begin
                    release_cnt = bump(release_cnt);
                    if (release_cnt > rel_lim)
                        request(ST_ERROR);
                end
                ST_IDLE_UP, ST_IDLE_DOWN: idle_tick(sample);
                default: go_error();
            endcase
        endfunction

        function void take_item(item_t it);
            result_t r;
            if (first_item)
            begin
                first_item = 1'b0;
                if (it.upper_switch)
                begin
                    mode          = ST_REL_UP;
                    entry_pending = 1'b1;
                end
            end
            case (it.opcode)
                OP_UPPER:
                begin
                    if (mode == ST_MOVE_UP && it.upper_switch)
                        request(ST_REL_UP);
                    else if (mode == ST_REL_UP && !it.upper_switch)
                        request(ST_IDLE_UP);
                end
                OP_LOWER:
                begin
                    if (mode == ST_MOVE_DOWN && it.lower_switch)
                        request(ST_REL_DOWN);
                    else if (mode == ST_REL_DOWN && !it.lower_switch)
                        request(ST_IDLE_DOWN);
                end
                OP_BUTTON:
                begin
                    if (it.set_pressed)
                    begin
                        if (mode == ST_IDLE_UP || mode == ST_IDLE_DOWN)
                            capture = 1'b1;
                    end
                    else if (it.close_pressed)
                    begin
                        if (mode == ST_IDLE_UP)
                            request(ST_MOVE_DOWN);
                    end
                    else if (it.open_pressed)
                    begin
                        if (mode == ST_IDLE_DOWN)
                            request(ST_MOVE_UP);
                    end
                end
                default: ;
            endcase
            run_entry(it.upper_switch, it.lower_switch);
            if (it.opcode == OP_TICK)
            begin
                tick(it.light_sample);
                run_entry(it.upper_switch, it.lower_switch);
            end
            r.mode      = mode;
            r.motor     = motor;
            r.threshold = thr;
            r.capture   = capture;
            r.confirm   = light_cnt;
            owed_results.push_back(r);
            items_seen++;
            mode_hits[int'(mode)]++;
        endfunction

        function int waiting();
            return owed_results.size();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                $error("%s mismatch on result %0d: expected %0d, got %0d",
                       name, results_seen, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                $error("result with no item waiting: door_state %0d", got.mode);
                return;
            end
            want = owed_results.pop_front();
            compare_field("door_state", 16'(want.mode), 16'(got.mode));
            compare_field("motor_drive", 16'(want.motor), 16'(got.motor));
            compare_field("threshold_now", want.threshold, got.threshold);
            compare_field("capture_armed", 16'(want.capture), 16'(got.capture));
            compare_field("confirm_ticks", 16'(want.confirm), 16'(got.confirm));
            results_seen++;
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    door_in_if #(.SAMPLE_BITS(LIGHT_W)) in_ch ();
    door_out_if                         out_ch ();

    door_result_board board = new();

    int    cycles       = 0;
    int    phases       = 0;
    int    send_stretch = 0;
    bit    send_eager   = 1'b0;
    int    recv_stretch = 0;
    bit    recv_eager   = 1'b0;
    bit    held_off     = 1'b0;
    string end_path     = "none";

    door_motor_sequencer_top #(.SAMPLE_BITS(LIGHT_W)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_door_motor_sequencer_top failed");
            $finish;
        end
    end

    // offer one item, wait for the handshake, then let the predictor see it
    // valid stays up after acceptance so back-to-back items need one assignment
    task automatic send_item(input item_t it);
        int gap;
        if (send_stretch == 0)
        begin
            // stretches of gap-free traffic mixed with gappy ones
            send_stretch = $urandom_range(10, 60);
            send_eager   = ($urandom_range(0, 3) == 0);
        end
        send_stretch--;
        gap = send_eager ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= it.opcode;
        in_ch.upper_switch  <= it.upper_switch;
        in_ch.lower_switch  <= it.lower_switch;
        in_ch.set_pressed   <= it.set_pressed;
        in_ch.close_pressed <= it.close_pressed;
        in_ch.open_pressed  <= it.open_pressed;
        in_ch.light_sample  <= it.light_sample;
        // ready is stable mid-cycle, so looking at the falling edge avoids races
        do @(negedge clk); while (in_ch.ready !== 1'b1);
        @(posedge clk);
        board.take_item(it);
    endtask

    task automatic send_fields(input opcode_t op, input int up_sw, input int low_sw,
                               input int set_b, input int close_b, input int open_b,
                               input int sample);
        item_t it;
        it.opcode        = op;
        it.upper_switch  = 1'(up_sw);
        it.lower_switch  = 1'(low_sw);
        it.set_pressed   = 1'(set_b);
        it.close_pressed = 1'(close_b);
        it.open_pressed  = 1'(open_b);
        it.light_sample  = LIGHT_W'(sample);
        send_item(it);
    endtask

    // drop valid and wait out every owed result plus the pipeline depth
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (board.waiting() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, applied at the next edge; caller lowers the enable afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // pick the next item from the predicted state: mostly well-formed steps
    // that keep the door cycling, with ignored events sprinkled in as noise
    function automatic item_t pick_item();
        item_t it;
        int    roll;
        int    top;
        int    lvl;
        it.opcode        = opcode_t'(2'($urandom_range(0, 3)));
        it.upper_switch  = 1'($urandom_range(0, 1));
        it.lower_switch  = 1'($urandom_range(0, 1));
        it.set_pressed   = 1'($urandom_range(0, 1));
        it.close_pressed = 1'($urandom_range(0, 1));
        it.open_pressed  = 1'($urandom_range(0, 1));
        it.light_sample  = LIGHT_W'($urandom_range(0, SAMPLE_MAX));
        roll = $urandom_range(0, 99);
        case (board.mode)
            ST_MOVE_UP, ST_MOVE_DOWN:
            begin
                if (roll < 55 && board.travel_cnt < board.move_lim)
                    it.opcode = OP_TICK;
                else if (roll < 80)
                begin
                    // buttons, the far switch, or the near switch still released
                    case ($urandom_range(0, 2))
                        0: it.opcode = OP_BUTTON;
                        1: it.opcode = (board.mode == ST_MOVE_UP) ? OP_LOWER : OP_UPPER;
                        default:
                        begin
                            it.opcode       = (board.mode == ST_MOVE_UP) ? OP_UPPER : OP_LOWER;
                            it.upper_switch = 1'b0;
                            it.lower_switch = 1'b0;
                        end
                    endcase
                end
                else if (board.mode == ST_MOVE_UP)
                begin
                    it.opcode       = OP_UPPER;
                    it.upper_switch = 1'b1;
                end
                else
                begin
                    it.opcode       = OP_LOWER;
                    it.lower_switch = 1'b1;
                end
            end
            ST_REL_UP, ST_REL_DOWN:
            begin
                if (roll < 55 && board.release_cnt < board.rel_lim)
                    it.opcode = OP_TICK;
                else if (roll < 80)
                begin
                    // near switch still pressed, or events that do not apply
                    case ($urandom_range(0, 2))
                        0: it.opcode = OP_BUTTON;
                        1: it.opcode = (board.mode == ST_REL_UP) ? OP_LOWER : OP_UPPER;
                        default:
                        begin
                            it.opcode       = (board.mode == ST_REL_UP) ? OP_UPPER : OP_LOWER;
                            it.upper_switch = 1'b1;
                            it.lower_switch = 1'b1;
                        end
                    endcase
                end
                else if (board.mode == ST_REL_UP)
                begin
                    it.opcode       = OP_UPPER;
                    it.upper_switch = 1'b0;
                end
                else
                begin
                    it.opcode       = OP_LOWER;
                    it.lower_switch = 1'b0;
                end
            end
            ST_IDLE_UP, ST_IDLE_DOWN:
            begin
                if (roll < 4)
                begin
                    // arm a threshold capture, set hides the other buttons
                    it.opcode      = OP_BUTTON;
                    it.set_pressed = 1'b1;
                end
                else if (roll < 7)
                begin
                    // manual move, switches must read released at move entry
                    it.opcode       = OP_BUTTON;
                    it.set_pressed  = 1'b0;
                    it.upper_switch = 1'b0;
                    it.lower_switch = 1'b0;
                    if (board.mode == ST_IDLE_UP)
                        it.close_pressed = 1'b1;
                    else
                    begin
                        it.close_pressed = 1'b0;
                        it.open_pressed  = 1'b1;
                    end
                end
                else if (roll < 12)
                begin
                    if ($urandom_range(0, 1) == 1)
                        it.opcode = opcode_t'(2'($urandom_range(1, 2)));
                    else
                    begin
                        // wrong button for this idle state: ignored
                        it.opcode        = OP_BUTTON;
                        it.set_pressed   = 1'b0;
                        it.close_pressed = (board.mode == ST_IDLE_DOWN);
                    end
                end
                else
                begin
                    it.opcode       = OP_TICK;
                    it.upper_switch = 1'b0;
                    it.lower_switch = 1'b0;
                    // mostly samples that satisfy the light condition
                    if (!board.capture && $urandom_range(0, 9) != 0)
                    begin
                        if (board.mode == ST_IDLE_UP)
                        begin
                            top = int'(board.thr) - 1;
                            if (top > SAMPLE_MAX)
                                top = SAMPLE_MAX;
                            if (top >= 0)
                                it.light_sample = LIGHT_W'($urandom_range(0, top));
                        end
                        else
                        begin
                            lvl = int'(board.thr) + int'(board.hyst);
                            if (lvl < SAMPLE_MAX)
                                it.light_sample = LIGHT_W'($urandom_range(lvl + 1, SAMPLE_MAX));
                            else
                                it.light_sample = LIGHT_W'($urandom_range(SAMPLE_MAX - 127,
                                                                          SAMPLE_MAX));
                        end
                    end
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    // one setting of all five registers, then a stretch of random traffic
    task automatic run_phase(input logic [15:0] thr, input logic [7:0] mv, input logic [7:0] rl,
                             input logic [7:0] cc, input logic [9:0] hy);
        settle();
        write_reg(CFG_START_THRESHOLD, thr);
        write_reg(CFG_MOVE_LIMIT, 16'(mv));
        write_reg(CFG_RELEASE_LIMIT, 16'(rl));
        write_reg(CFG_CONFIRM_COUNT, 16'(cc));
        write_reg(CFG_HYSTERESIS, 16'(hy));
        cfg_we <= 1'b0;
        phases++;
        repeat (PHASE_ITEMS) send_item(pick_item());
    endtask

    function automatic bit at_end_state(int kind);
        case (kind)
            END_BY_TRAVEL:  return board.mode == ST_MOVE_UP || board.mode == ST_MOVE_DOWN;
            END_BY_RELEASE: return board.mode == ST_REL_UP || board.mode == ST_REL_DOWN;
            default:        return board.mode == ST_IDLE_UP || board.mode == ST_IDLE_DOWN;
        endcase
    endfunction

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin : result_side
        result_t got;
        int      stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (recv_stretch == 0)
            begin
                recv_stretch = $urandom_range(10, 60);
                recv_eager   = ($urandom_range(0, 3) == 0);
            end
            recv_stretch--;
            stall = recv_eager ? 0 : $urandom_range(0, 18);
            if (!held_off && board.results_seen >= HOLD_OFF_AT)
            begin
                // long hold-off while the sender keeps pushing
                held_off = 1'b1;
                stall    = HOLD_OFF_CYCLES;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(negedge clk); while (out_ch.valid !== 1'b1);
            got.mode      = mode_t'(out_ch.door_state);
            got.motor     = drive_t'(out_ch.motor_drive);
            got.threshold = out_ch.threshold_now;
            got.capture   = out_ch.capture_armed;
            got.confirm   = out_ch.confirm_ticks;
            @(posedge clk);
            board.check_result(got);
        end
    end

    initial
    begin : stimulus
        int kind;
        int guard;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.opcode        = OP_TICK;
        in_ch.upper_switch  = 1'b0;
        in_ch.lower_switch  = 1'b0;
        in_ch.set_pressed   = 1'b0;
        in_ch.close_pressed = 1'b0;
        in_ch.open_pressed  = 1'b0;
        in_ch.light_sample  = '0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_START_THRESHOLD;
        cfg_data            = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening at reset settings
        // power-on with the upper switch pressed: straight to releasing up
        send_fields(OP_UPPER, 1, 1, 1, 1, 1, SAMPLE_MAX);
        send_fields(OP_TICK, 1, 1, 0, 0, 0, 0);
        send_fields(OP_BUTTON, 0, 0, 1, 0, 0, 0);          // set outside idle does nothing
        send_fields(OP_UPPER, 0, 0, 0, 0, 0, 0);           // upper released: idle up
        send_fields(OP_BUTTON, 0, 0, 1, 1, 0, 0);          // set arms capture, hides close
        send_fields(OP_TICK, 0, 0, 0, 0, 0, SAMPLE_MAX);   // capture takes the top sample
        send_fields(OP_TICK, 0, 0, 0, 0, 0, 0);            // darker than threshold
        send_fields(OP_BUTTON, 0, 0, 0, 0, 1, 0);          // open ignored in idle up
        send_fields(OP_BUTTON, 0, 0, 0, 1, 1, 0);          // close wins over open: move down
        send_fields(OP_UPPER, 1, 0, 0, 0, 0, 0);           // wrong switch, ignored
        send_fields(OP_TICK, 0, 0, 0, 0, 0, 512);
        send_fields(OP_LOWER, 0, 1, 0, 0, 0, 0);           // lower end reached
        send_fields(OP_LOWER, 0, 1, 0, 0, 0, 0);           // still pressed, ignored
        send_fields(OP_TICK, 0, 0, 0, 0, 0, 1);
        send_fields(OP_LOWER, 0, 0, 0, 0, 0, 0);           // released: idle down
        send_fields(OP_BUTTON, 0, 0, 0, 1, 1, 0);          // close hides open, no move
        send_fields(OP_BUTTON, 0, 0, 1, 0, 0, 0);
        send_fields(OP_TICK, 0, 0, 0, 0, 0, 0);            // capture a zero threshold
        send_fields(OP_TICK, 0, 0, 0, 0, 0, 16);           // just above threshold plus hysteresis
        send_fields(OP_TICK, 0, 0, 0, 0, 0, SAMPLE_MAX);
        send_fields(OP_TICK, 0, 0, 0, 0, 0, 15);           // at the level: count restarts
        send_fields(OP_BUTTON, 0, 0, 0, 0, 1, 0);          // manual open: move up
        send_fields(OP_UPPER, 1, 0, 0, 0, 0, 0);
        send_fields(OP_UPPER, 0, 0, 0, 0, 0, 0);

        // register extremes: blank thresholds fall back to the default,
        // zero limits forbid ticks, and a threshold near the top checks that
        // threshold plus hysteresis does not wrap
        run_phase(16'h0000, 8'd254, 8'd254, 8'd0, 10'd0);
        run_phase(16'hFFFF, 8'd0, 8'd0, 8'd254, 10'd1023);
        run_phase(16'hFFF0, 8'd1, 8'd1, 8'd1, 10'd1023);
        run_phase(16'h0001, 8'd3, 8'd2, 8'd5, 10'd500);
        repeat (4)
        begin
            run_phase(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(1, SAMPLE_MAX)),
                      8'($urandom_range(0, 254)), 8'($urandom_range(0, 254)),
                      8'($urandom_range(0, 40)), 10'($urandom_range(0, 80)));
        end

        // error is terminal, so it comes last, by one of three routes
        kind  = $urandom_range(END_BY_TRAVEL, END_BY_ENDSTOP);
        guard = 0;
        while (!at_end_state(kind) && guard < 3000)
        begin
            send_item(pick_item());
            guard++;
        end
        guard = 0;
        if (kind == END_BY_ENDSTOP)
        begin
            end_path = "end-stop check";
            // move request while a limit switch still reads pressed
            if (board.mode == ST_IDLE_UP)
                send_fields(OP_BUTTON, 1, 0, 0, 1, 0, 0);
            else
                send_fields(OP_BUTTON, 0, 1, 0, 0, 1, 0);
        end
        else
        begin
            end_path = (kind == END_BY_TRAVEL) ? "move timeout" : "release timeout";
            while (board.mode != ST_ERROR && guard < 3000)
            begin
                send_fields(OP_TICK, 0, 0, 0, 0, 0, $urandom_range(0, SAMPLE_MAX));
                guard++;
            end
        end
        // everything is ignored in error
        repeat (20) send_item(pick_item());

        settle();
        repeat (10) @(posedge clk);
        $display("covered %0d items over %0d register settings, %0d threshold captures, ended by %s",
                 board.items_seen, phases, board.captures_taken, end_path);
        $display("states seen: moving %0d, releasing %0d, idle %0d, error %0d",
                 board.mode_hits[ST_MOVE_UP] + board.mode_hits[ST_MOVE_DOWN],
                 board.mode_hits[ST_REL_UP] + board.mode_hits[ST_REL_DOWN],
                 board.mode_hits[ST_IDLE_UP] + board.mode_hits[ST_IDLE_DOWN],
                 board.mode_hits[ST_ERROR]);
        if (board.mismatches == 0 && board.waiting() == 0)
            $display("tb_door_motor_sequencer_top passed");
        else
            $display("tb_door_motor_sequencer_top failed");
        $finish;
    end

endmodule

### filelist.f
src/dms_pkg.sv
src/dms_if.sv
src/dms_cfg_regs.sv
src/dms_seq.sv
src/door_motor_sequencer_top.sv
tb/tb_door_motor_sequencer_top.sv
